@@ hw/rtl/rnes_pkg.sv @@
// Shared constants and types for the raster neighbor edge scan core.
// Holds the line store entry layout, the pipeline stage record and register codes.
// Has no dependencies of its own.
package rnes_pkg;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_MAX_NODES = 65536;

    localparam int ID_W   = 16;
    localparam int RW_W   = 11;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam logic [RW_W-1:0] ROW_WIDTH_RESET = 11'd1024;

    // Register index, taken from the word address bits of paddr.
    localparam logic [ADDR_W-3:0] REG_ROW_WIDTH = 1'b0;

    typedef struct packed {
        logic            live;
        logic [ID_W-1:0] id;
    } entry_t;

    typedef struct packed {
        logic            live;
        logic [ID_W-1:0] id;
        logic            first_row;
        logic            has_left;
        logic            has_upright;
        entry_t          left;
        logic            overflow;
    } stage_t;

    typedef struct packed {
        logic            node_valid;
        logic [ID_W-1:0] node_id;
        logic            upleft_valid;
        logic [ID_W-1:0] upleft_id;
        logic            up_valid;
        logic [ID_W-1:0] up_id;
        logic            upright_valid;
        logic [ID_W-1:0] upright_id;
        logic            left_valid;
        logic [ID_W-1:0] left_id;
        logic            id_overflow;
    } result_t;

endpackage

@@ hw/rtl/raster_neighbor_edge_scan_core.sv @@
// Top level of the raster neighbor edge scan core: line store, id counter and result stage.
// Depends on rnes_pkg for constants, the entry layout and the stage records.
//
// Usage: cells enter in raster order on the cell channel (cell_valid, cell_stall,
// cell_live, frame_start); an item is taken at a clock edge with cell_valid high and
// cell_stall low. A cell with frame_start high restarts the column, the first-row
// state and the node ids. Every cell gives exactly one item on the result channel
// (result_valid, result_stall): its node id and the ids of its live up-left, up,
// up-right and left neighbors, plus the sticky id_overflow flag of the frame.
// An accepted cell is registered in the read stage, then in the output register.
// Throughput is one cell per clock while result_stall does not hold the pipeline, set
// by the line store, which takes one write and two reads each cycle and writes the
// current cell's entry in the same cycle that it reads the previous row's entries, so
// no forwarding is needed. When the receiver stalls, the result holds in the
// output register, one more cell waits in the read stage, and cell_stall rises.
// Reset clears the handshake state, the column, the ids and the overflow flag, and
// sets row_width to 1024; the line store needs no clearing pass. The user must write
// row_width over APB at byte address 0 while the core is idle; the core does not check.
module raster_neighbor_edge_scan_core #(
    parameter int MAX_WIDTH = rnes_pkg::DEF_MAX_WIDTH,
    parameter int MAX_NODES = rnes_pkg::DEF_MAX_NODES
) (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rnes_pkg::ADDR_W-1:0]  paddr,
    input  logic [rnes_pkg::DATA_W-1:0]  pwdata,
    output logic [rnes_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,

    input  logic                         cell_valid,
    output logic                         cell_stall,
    input  logic                         cell_live,
    input  logic                         frame_start,

    output logic                         result_valid,
    input  logic                         result_stall,
    output logic                         node_valid,
    output logic [rnes_pkg::ID_W-1:0]    node_id,
    output logic                         upleft_valid,
    output logic [rnes_pkg::ID_W-1:0]    upleft_id,
    output logic                         up_valid,
    output logic [rnes_pkg::ID_W-1:0]    up_id,
    output logic                         upright_valid,
    output logic [rnes_pkg::ID_W-1:0]    upright_id,
    output logic                         left_valid,
    output logic [rnes_pkg::ID_W-1:0]    left_id,
    output logic                         id_overflow
);

    localparam int AW       = $clog2(MAX_WIDTH);
    localparam int CW       = $clog2(MAX_WIDTH + 1);
    localparam int ID_LIMIT = (MAX_NODES > 65536) ? 65536 : MAX_NODES;
    localparam int NW       = $clog2(ID_LIMIT + 1);
    localparam int DW       = rnes_pkg::DATA_W;
    localparam int IW       = rnes_pkg::ID_W;

    logic [rnes_pkg::RW_W-1:0] row_width_reg;
    logic                      cfg_write;

    logic [CW-1:0]             col_reg;
    logic                      first_row_reg;
    logic [NW-1:0]             next_id_reg;
    logic                      overflow_reg;
    rnes_pkg::entry_t          left_cell_reg;

    rnes_pkg::entry_t          row_mem [MAX_WIDTH];
    rnes_pkg::entry_t          rd_up_reg;
    rnes_pkg::entry_t          rd_upright_reg;
    rnes_pkg::entry_t          prev_up_reg;

    logic                      s1_valid_reg;
    rnes_pkg::stage_t          s1_reg;
    rnes_pkg::stage_t          s1_next;

    logic                      out_valid_reg;
    rnes_pkg::result_t         out_reg;
    rnes_pkg::result_t         out_next;

    logic                      accept;
    logic                      out_load;

    logic [CW-1:0]             w_eff;
    logic [CW-1:0]             col_eff;
    logic [CW-1:0]             col_plus;
    logic                      first_eff;
    logic [NW-1:0]             id_base;
    logic                      ovf_base;
    rnes_pkg::entry_t          left_base;
    logic [NW-1:0]             id_after;
    logic                      ovf_after;
    logic [IW-1:0]             id_cur;
    rnes_pkg::entry_t          me;
    logic [AW-1:0]             upright_addr;
    rnes_pkg::entry_t          up_masked;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[rnes_pkg::ADDR_W-1:2] == rnes_pkg::REG_ROW_WIDTH);

    always_comb
    begin
        if (paddr[rnes_pkg::ADDR_W-1:2] == rnes_pkg::REG_ROW_WIDTH)
        begin
            prdata = DW'(row_width_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= rnes_pkg::ROW_WIDTH_RESET;
        end
        else if (cfg_write)
        begin
            row_width_reg <= pwdata[rnes_pkg::RW_W-1:0];
        end
    end

    // Handshake and pipeline advance.
    assign out_load   = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign cell_stall = s1_valid_reg && !out_load;
    assign accept     = cell_valid && !cell_stall;

    // Position, id assignment and the line store entry of the incoming cell.
    always_comb
    begin
        if (row_width_reg == '0)
        begin
            w_eff = CW'(1);
        end
        else if (32'(row_width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = CW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = CW'(row_width_reg);
        end

        if (frame_start)
        begin
            col_eff   = '0;
            first_eff = 1'b1;
            id_base   = '0;
            ovf_base  = 1'b0;
            left_base = '0;
        end
        else if (col_reg >= w_eff)
        begin
            col_eff   = '0;
            first_eff = 1'b0;
            id_base   = next_id_reg;
            ovf_base  = overflow_reg;
            left_base = '0;
        end
        else
        begin
            col_eff   = col_reg;
            first_eff = first_row_reg;
            id_base   = next_id_reg;
            ovf_base  = overflow_reg;
            left_base = left_cell_reg;
        end

        col_plus = col_eff + CW'(1);

        id_after  = id_base;
        ovf_after = ovf_base;
        id_cur    = '0;
        if (cell_live)
        begin
            if (id_base != NW'(ID_LIMIT))
            begin
                id_cur   = IW'(id_base);
                id_after = id_base + NW'(1);
            end
            else
            begin
                id_cur    = IW'(ID_LIMIT - 1);
                ovf_after = 1'b1;
            end
        end
        me.live = cell_live;
        me.id   = id_cur;

        s1_next.live        = cell_live;
        s1_next.id          = id_cur;
        s1_next.first_row   = first_eff;
        s1_next.has_left    = (col_eff != '0);
        s1_next.has_upright = (col_plus < w_eff);
        s1_next.left        = left_base;
        s1_next.overflow    = ovf_after;

        if (s1_next.has_upright)
        begin
            upright_addr = col_plus[AW-1:0];
        end
        else
        begin
            upright_addr = col_eff[AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            first_row_reg <= 1'b1;
            next_id_reg   <= '0;
            overflow_reg  <= 1'b0;
            left_cell_reg <= '0;
        end
        else if (accept)
        begin
            col_reg       <= col_plus;
            first_row_reg <= first_eff;
            next_id_reg   <= id_after;
            overflow_reg  <= ovf_after;
            left_cell_reg <= me;
        end
    end

    // Line store: the reads return the previous row's entries while this cell's entry
    // is written.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_mem[col_eff[AW-1:0]] <= me;
            rd_up_reg                <= row_mem[col_eff[AW-1:0]];
            rd_upright_reg           <= row_mem[upright_addr];
            s1_reg                   <= s1_next;
        end
    end

    // Result stage.
    always_comb
    begin
        if (s1_reg.first_row)
        begin
            up_masked = '0;
        end
        else
        begin
            up_masked = rd_up_reg;
        end

        out_next.node_valid    = s1_reg.live;
        out_next.node_id       = s1_reg.live ? s1_reg.id : '0;
        out_next.up_valid      = s1_reg.live && up_masked.live;
        out_next.up_id         = out_next.up_valid ? up_masked.id : '0;
        out_next.upright_valid = s1_reg.live && !s1_reg.first_row && s1_reg.has_upright
                                 && rd_upright_reg.live;
        out_next.upright_id    = out_next.upright_valid ? rd_upright_reg.id : '0;
        out_next.upleft_valid  = s1_reg.live && s1_reg.has_left && prev_up_reg.live;
        out_next.upleft_id     = out_next.upleft_valid ? prev_up_reg.id : '0;
        out_next.left_valid    = s1_reg.live && s1_reg.has_left && s1_reg.left.live;
        out_next.left_id       = out_next.left_valid ? s1_reg.left.id : '0;
        out_next.id_overflow   = s1_reg.overflow;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= accept || (s1_valid_reg && !out_load);
            out_valid_reg <= out_load || (out_valid_reg && result_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg     <= out_next;
            prev_up_reg <= up_masked;
        end
    end

    assign result_valid  = out_valid_reg;
    assign node_valid    = out_reg.node_valid;
    assign node_id       = out_reg.node_id;
    assign upleft_valid  = out_reg.upleft_valid;
    assign upleft_id     = out_reg.upleft_id;
    assign up_valid      = out_reg.up_valid;
    assign up_id         = out_reg.up_id;
    assign upright_valid = out_reg.upright_valid;
    assign upright_id    = out_reg.upright_id;
    assign left_valid    = out_reg.left_valid;
    assign left_id       = out_reg.left_id;
    assign id_overflow   = out_reg.id_overflow;

    // The id counter never runs past the number of ids.
    a_id_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(next_id_reg) <= ID_LIMIT)
        else $error("node id counter past its limit");

    // A neighbor is only reported for a cell that became a node.
    a_nbr_needs_node: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (upleft_valid || up_valid || upright_valid || left_valid)
        |-> node_valid)
        else $error("neighbor reported for a dead cell");

    // Once ids are used up, every later node gets the last id.
    a_sat_id: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && node_valid && id_overflow |-> node_id == IW'(ID_LIMIT - 1))
        else $error("saturated node has the wrong id");

    // Without saturation, a live left neighbor is the node just before this one.
    a_left_seq: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && left_valid && !id_overflow |-> node_id == IW'(left_id + IW'(1)))
        else $error("left neighbor id out of sequence");

endmodule

@@ bench/rnes_scan_checker.sv @@
// Checker for the raster neighbor edge scan core: watches the APB port and both item channels,
// predicts each cell's neighbor report and compares it field by field with what the core sends.
// Depends on rnes_pkg for the entry and result layouts and the register codes.
`timescale 1ns / 100ps

module rnes_scan_checker #(
    parameter int MAX_WIDTH = rnes_pkg::DEF_MAX_WIDTH,
    parameter int MAX_NODES = rnes_pkg::DEF_MAX_NODES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rnes_pkg::ADDR_W-1:0]  paddr,
    input  logic [rnes_pkg::DATA_W-1:0]  pwdata,
    input  logic [rnes_pkg::DATA_W-1:0]  prdata,
    input  logic                         pready,
    input  logic                         cell_valid,
    input  logic                         cell_stall,
    input  logic                         cell_live,
    input  logic                         frame_start,
    input  logic                         result_valid,
    input  logic                         result_stall,
    input  rnes_pkg::result_t            seen,
    output int                           fail_count,
    output int                           pending,
    output int                           results_seen
);

    localparam int ID_LIMIT = (MAX_NODES > 65536) ? 65536 : MAX_NODES;
    localparam int IDW      = rnes_pkg::ID_W;

    rnes_pkg::entry_t            line_ids [MAX_WIDTH];
    rnes_pkg::entry_t            left_nb;
    rnes_pkg::entry_t            diag_nb;
    logic [16:0]                 id_count;
    int                          col;
    logic                        in_first_row;
    logic                        saturated;
    logic [rnes_pkg::RW_W-1:0]   width_reg;
    rnes_pkg::result_t           reports_due [$];

    initial fail_count = 0;
    initial results_seen = 0;
    initial pending = 0;

    function automatic bit count_miss();
        fail_count++;
        return fail_count <= 10;
    endfunction

    task automatic cmp_field(input string tag, input logic [IDW-1:0] want,
                             input logic [IDW-1:0] got);
        if (got !== want)
        begin
            if (count_miss())
                $display("result %0d: %s expected 0x%0h, got 0x%0h",
                         results_seen, tag, want, got);
        end
    endtask

    function automatic rnes_pkg::result_t scan_cell(input logic live, input logic fs);
        rnes_pkg::result_t r;
        rnes_pkg::entry_t  above;
        rnes_pkg::entry_t  above_right;
        rnes_pkg::entry_t  diag;
        rnes_pkg::entry_t  lft;
        rnes_pkg::entry_t  mine;
        logic [16:0]       nid;
        int                w;
        w = int'(width_reg);
        if (w < 1)
            w = 1;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        if (fs)
        begin
            col = 0;
            in_first_row = 1'b1;
            id_count = '0;
            saturated = 1'b0;
            left_nb = '0;
            diag_nb = '0;
        end
        else if (col >= w)
        begin
            col = 0;
            in_first_row = 1'b0;
            left_nb = '0;
            diag_nb = '0;
        end
        above = '0;
        above_right = '0;
        diag = '0;
        lft = '0;
        mine = '0;
        nid = '0;
        if (!in_first_row)
        begin
            above = line_ids[col];
            if (col + 1 < w)
                above_right = line_ids[col + 1];
        end
        if (col > 0)
        begin
            diag = diag_nb;
            lft = left_nb;
        end
        if (live)
        begin
            if (id_count < ID_LIMIT)
            begin
                nid = id_count;
                id_count = id_count + 17'd1;
            end
            else
            begin
                nid = 17'(ID_LIMIT - 1);
                saturated = 1'b1;
            end
            mine.live = 1'b1;
            mine.id = nid[IDW-1:0];
        end
        r = '0;
        r.node_valid = live;
        r.node_id = mine.id;
        r.upleft_valid = live && diag.live;
        r.upleft_id = r.upleft_valid ? diag.id : '0;
        r.up_valid = live && above.live;
        r.up_id = r.up_valid ? above.id : '0;
        r.upright_valid = live && above_right.live;
        r.upright_id = r.upright_valid ? above_right.id : '0;
        r.left_valid = live && lft.live;
        r.left_id = r.left_valid ? lft.id : '0;
        r.id_overflow = saturated;
        line_ids[col] = mine;
        left_nb = mine;
        diag_nb = above;
        col++;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rnes_pkg::result_t want;
        if (!rst_n)
        begin
            id_count = '0;
            col = 0;
            in_first_row = 1'b1;
            saturated = 1'b0;
            left_nb = '0;
            diag_nb = '0;
            width_reg = rnes_pkg::ROW_WIDTH_RESET;
            reports_due.delete();
            pending = 0;
        end
        else
        begin
            if (psel && penable && pready
                && paddr[rnes_pkg::ADDR_W-1:2] == rnes_pkg::REG_ROW_WIDTH)
            begin
                if (pwrite)
                    width_reg = pwdata[rnes_pkg::RW_W-1:0];
                else if (prdata !== {{(rnes_pkg::DATA_W-rnes_pkg::RW_W){1'b0}}, width_reg})
                begin
                    if (count_miss())
                        $display("row_width readback expected 0x%0h, got 0x%0h",
                                 width_reg, prdata);
                end
            end
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (reports_due.size() == 0)
                begin
                    if (count_miss())
                        $display("result %0d arrived with no cell waiting", results_seen);
                end
                else
                begin
                    want = reports_due.pop_front();
                    cmp_field("node_valid", IDW'(want.node_valid), IDW'(seen.node_valid));
                    cmp_field("node_id", want.node_id, seen.node_id);
                    cmp_field("upleft_valid", IDW'(want.upleft_valid),
                              IDW'(seen.upleft_valid));
                    cmp_field("upleft_id", want.upleft_id, seen.upleft_id);
                    cmp_field("up_valid", IDW'(want.up_valid), IDW'(seen.up_valid));
                    cmp_field("up_id", want.up_id, seen.up_id);
                    cmp_field("upright_valid", IDW'(want.upright_valid),
                              IDW'(seen.upright_valid));
                    cmp_field("upright_id", want.upright_id, seen.upright_id);
                    cmp_field("left_valid", IDW'(want.left_valid), IDW'(seen.left_valid));
                    cmp_field("left_id", want.left_id, seen.left_id);
                    cmp_field("id_overflow", IDW'(want.id_overflow),
                              IDW'(seen.id_overflow));
                end
            end
            if (cell_valid && !cell_stall)
                reports_due.push_back(scan_cell(cell_live, frame_start));
            pending = reports_due.size();
        end
    end

endmodule

@@ bench/tb_top.sv @@
// Top of the raster neighbor edge scan bench: clock, reset, APB writes, cell stimulus and
// result stalls, with a watchdog and the final verdict.
// Depends on rnes_pkg, the core raster_neighbor_edge_scan_core and rnes_scan_checker.
`timescale 1ns / 100ps

module tb_top;

    localparam int HOLD_CYCLES = 300;
    localparam int STUCK_LIMIT = 2000;
    localparam int RAND_CELLS  = 320;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [rnes_pkg::ADDR_W-1:0]   paddr = '0;
    logic [rnes_pkg::DATA_W-1:0]   pwdata = '0;
    logic [rnes_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    logic                          cell_valid = 1'b0;
    logic                          cell_stall;
    logic                          cell_live = 1'b0;
    logic                          frame_start = 1'b0;
    logic                          result_valid;
    logic                          result_stall = 1'b0;
    logic                          node_valid;
    logic [rnes_pkg::ID_W-1:0]     node_id;
    logic                          upleft_valid;
    logic [rnes_pkg::ID_W-1:0]     upleft_id;
    logic                          up_valid;
    logic [rnes_pkg::ID_W-1:0]     up_id;
    logic                          upright_valid;
    logic [rnes_pkg::ID_W-1:0]     upright_id;
    logic                          left_valid;
    logic [rnes_pkg::ID_W-1:0]     left_id;
    logic                          id_overflow;
    rnes_pkg::result_t             dut_result;

    int fail_count;
    int pending;
    int results_seen;
    int stuck = 0;
    int cells_sent = 0;
    int frames_sent = 0;
    int widths_set = 0;
    int cur_width = rnes_pkg::DEF_MAX_WIDTH;
    bit calm = 1'b0;
    bit hold_pending = 1'b0;

    always #1 clk = ~clk;

    raster_neighbor_edge_scan_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .cell_valid    (cell_valid),
        .cell_stall    (cell_stall),
        .cell_live     (cell_live),
        .frame_start   (frame_start),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .node_valid    (node_valid),
        .node_id       (node_id),
        .upleft_valid  (upleft_valid),
        .upleft_id     (upleft_id),
        .up_valid      (up_valid),
        .up_id         (up_id),
        .upright_valid (upright_valid),
        .upright_id    (upright_id),
        .left_valid    (left_valid),
        .left_id       (left_id),
        .id_overflow   (id_overflow)
    );

    assign dut_result = {node_valid, node_id, upleft_valid, upleft_id, up_valid, up_id,
                         upright_valid, upright_id, left_valid, left_id, id_overflow};

    rnes_scan_checker scan_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .cell_valid   (cell_valid),
        .cell_stall   (cell_stall),
        .cell_live    (cell_live),
        .frame_start  (frame_start),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .seen         (dut_result),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(12, 40);
        return $urandom_range(1, 3);
    endfunction

    task automatic send_cell(input logic live, input logic fs);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            cell_valid <= 1'b0;
            repeat (gap_len()) @(posedge clk);
        end
        cell_valid <= 1'b1;
        cell_live <= live;
        frame_start <= fs;
        do @(posedge clk); while (cell_stall !== 1'b0);
        cells_sent++;
    endtask

    task automatic send_frame(input int rows, input int tail, input int density);
        int n;
        n = rows * cur_width + tail;
        for (int i = 0; i < n; i++)
            send_cell($urandom_range(1, 100) <= density,
                      i == 0 || $urandom_range(0, 199) == 0);
        frames_sent++;
    endtask

    task automatic drain();
        cell_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_width(input logic [rnes_pkg::RW_W-1:0] w);
        logic [rnes_pkg::DATA_W-1:0] word;
        word = $urandom();
        word[rnes_pkg::RW_W-1:0] = w;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {rnes_pkg::REG_ROW_WIDTH, 2'b00};
        pwdata <= word;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        cur_width = (w == 0) ? 1
                  : ((w > rnes_pkg::DEF_MAX_WIDTH) ? rnes_pkg::DEF_MAX_WIDTH : int'(w));
        widths_set++;
    endtask

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_stall <= 1'b0;
            end
            else if (calm)
            begin
                result_stall <= 1'b0;
            end
            else
            begin
                result_stall <= ($urandom_range(0, 2) == 0);
                repeat (gap_len() - 1) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cell_valid && !cell_stall) || (result_valid && !result_stall) || psel)
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (stuck >= STUCK_LIMIT)
        begin
            $display("Timeout: no handshake for %0d cycles", STUCK_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int base;
        int w;
        int d;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Cells before any frame start, at the reset width.
        calm = 1'b1;
        send_cell(1'b1, 1'b0);
        send_cell(1'b1, 1'b0);
        send_cell(1'b0, 1'b0);
        send_cell(1'b1, 1'b0);

        // A zero width behaves as a single column.
        drain();
        set_width('0);
        send_cell(1'b1, 1'b1);
        send_cell(1'b1, 1'b0);
        send_cell(1'b0, 1'b0);
        send_cell(1'b1, 1'b0);
        send_cell(1'b1, 1'b0);

        drain();
        set_width(11'd3);
        send_frame(2, 0, 100);

        // Shrinking the width past the current column starts a new row.
        drain();
        set_width(11'd5);
        send_frame(1, 3, 100);
        drain();
        set_width(11'd2);
        send_cell(1'b1, 1'b0);
        send_cell(1'b1, 1'b0);

        // An oversized width clamps to the maximum; the receiver holds off meanwhile.
        calm = 1'b0;
        drain();
        set_width(11'h7FF);
        hold_pending = 1'b1;
        send_frame(0, 40, 60);

        base = cells_sent;
        while (cells_sent - base < RAND_CELLS)
        begin
            drain();
            case ($urandom_range(0, 9))
                0:       w = 1;
                1:       w = $urandom_range(13, 40);
                default: w = $urandom_range(2, 12);
            endcase
            set_width(w[rnes_pkg::RW_W-1:0]);
            calm = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 3))
            begin
                case ($urandom_range(0, 5))
                    0:       d = 0;
                    1:       d = 100;
                    default: d = $urandom_range(20, 90);
                endcase
                send_frame($urandom_range(1, 4),
                           ($urandom_range(0, 9) < 3) ? $urandom_range(1, cur_width) : 0, d);
            end
        end

        drain();
        $display("Run covered %0d cells in %0d frames over %0d row width settings,",
                 cells_sent, frames_sent, widths_set);
        $display("with a zero width, a width cut mid-row and a long result hold; %0d mismatches.",
                 fail_count);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
